// ----- src/spwm_pkg.sv -----
package spwm_pkg;

  // field widths
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned REM_W   = 6;

  // speed limits and band edges
  localparam logic [SPEED_W-1:0] SPEED_TOP = 10'd996;
  localparam logic [SPEED_W-1:0] BAND4     = 10'd795;
  localparam logic [SPEED_W-1:0] BAND3     = 10'd595;
  localparam logic [SPEED_W-1:0] BAND2     = 10'd395;
  localparam logic [SPEED_W-1:0] BAND1     = 10'd195;

  // v/f curve corners: boost below, full sine above
  localparam logic [SPEED_W-1:0] SPD_BOOST = 10'd95;
  localparam logic [SPEED_W-1:0] SPD_BASE  = 10'd495;

  // amplitude slope 230/400 reduced to 23/40, tracked as quotient and remainder
  localparam logic [DUTY_W-1:0] AMP_LOW  = 8'd25;
  localparam logic [REM_W-1:0]  AMP_STEP = 6'd23;
  localparam logic [REM_W-1:0]  AMP_DEN  = 6'd40;
  localparam logic [REM_W-1:0]  AMP_WRAP = AMP_DEN - AMP_STEP;

  // phase offsets of phases b and c
  localparam logic [DUTY_W-1:0] OFS_B = 8'd84;
  localparam logic [DUTY_W-1:0] OFS_C = 8'd170;

  // duty values after reset
  localparam logic [DUTY_W-1:0] DUTY_RST_A = 8'd128;
  localparam logic [DUTY_W-1:0] DUTY_RST_B = 8'd240;
  localparam logic [DUTY_W-1:0] DUTY_RST_C = 8'd18;
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 8'd255;

  // period table generation
  localparam int unsigned PERIOD_NUM = 312500;
  localparam int unsigned PERIOD_OFS = 4;

  // tick register reset value
  localparam logic [CNT_W-1:0] TICKS_RST = 8'd1;

  typedef enum logic {
    CMD_RAMP   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_ACCEL = 1'b0,
    CFG_DECEL = 1'b1
  } cfg_idx_e;

  // ramp state seen by the waveform side
  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DUTY_W-1:0]  amp;
  } ramp_stat_t;

  localparam logic [7:0] WAVE_TAB [256] = '{
  8'h80,8'h83,8'h86,8'h89,8'h8c,8'h8f,8'h92,8'h95,8'h98,8'h9c,8'h9f,8'ha2,8'ha5,8'ha8,8'hab,8'hae,
  8'hb0,8'hb3,8'hb6,8'hb9,8'hbc,8'hbf,8'hc1,8'hc4,8'hc7,8'hc9,8'hcc,8'hce,8'hd1,8'hd3,8'hd5,8'hd8,
  8'hda,8'hdc,8'hde,8'he0,8'he2,8'he4,8'he6,8'he8,8'hea,8'hec,8'hed,8'hef,8'hf0,8'hf2,8'hf3,8'hf5,
  8'hf6,8'hf7,8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfc,8'hfd,8'hfe,8'hfe,8'hff,8'hff,8'hff,8'hff,8'hff,
  8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hfe,8'hfe,8'hfd,8'hfc,8'hfc,8'hfb,8'hfa,8'hf9,8'hf8,8'hf7,
  8'hf6,8'hf5,8'hf3,8'hf2,8'hf0,8'hef,8'hed,8'hec,8'hea,8'he8,8'he6,8'he4,8'he2,8'he0,8'hde,8'hdc,
  8'hda,8'hd8,8'hd5,8'hd3,8'hd1,8'hce,8'hcc,8'hc9,8'hc7,8'hc4,8'hc1,8'hbf,8'hbc,8'hb9,8'hb6,8'hb3,
  8'hb0,8'hae,8'hab,8'ha8,8'ha5,8'ha2,8'h9f,8'h9c,8'h98,8'h95,8'h92,8'h8f,8'h8c,8'h89,8'h86,8'h83,
  8'h80,8'h7c,8'h79,8'h76,8'h73,8'h70,8'h6d,8'h6a,8'h67,8'h63,8'h60,8'h5d,8'h5a,8'h57,8'h54,8'h51,
  8'h4f,8'h4c,8'h49,8'h46,8'h43,8'h40,8'h3e,8'h3b,8'h38,8'h36,8'h33,8'h31,8'h2e,8'h2c,8'h2a,8'h27,
  8'h25,8'h23,8'h21,8'h1f,8'h1d,8'h1b,8'h19,8'h17,8'h15,8'h13,8'h12,8'h10,8'h0f,8'h0d,8'h0c,8'h0a,
  8'h09,8'h08,8'h07,8'h06,8'h05,8'h04,8'h03,8'h03,8'h02,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,
  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h02,8'h03,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,
  8'h09,8'h0a,8'h0c,8'h0d,8'h0f,8'h10,8'h12,8'h13,8'h15,8'h17,8'h19,8'h1b,8'h1d,8'h1f,8'h21,8'h23,
  8'h25,8'h27,8'h2a,8'h2c,8'h2e,8'h31,8'h33,8'h36,8'h38,8'h3b,8'h3e,8'h40,8'h43,8'h46,8'h49,8'h4c,
  8'h4f,8'h51,8'h54,8'h57,8'h5a,8'h5d,8'h60,8'h63,8'h67,8'h6a,8'h6d,8'h70,8'h73,8'h76,8'h79,8'h7c};

  // speed band, 0 to 4
  function automatic logic [2:0] band_of(input logic [SPEED_W-1:0] s);
    logic [2:0] b;
    if (s > BAND4) b = 3'd4;
    else if (s > BAND3) b = 3'd3;
    else if (s > BAND2) b = 3'd2;
    else if (s > BAND1) b = 3'd1;
    else b = 3'd0;
    return b;
  endfunction

  function automatic logic [DUTY_W-1:0] wave_rom(input logic [DUTY_W-1:0] idx);
    return WAVE_TAB[idx];
  endfunction

  // pull a sine sample toward mid-scale, symmetric about the midpoint
  function automatic logic [DUTY_W-1:0] scale_sample(input logic [DUTY_W-1:0] raw,
                                                     input logic [DUTY_W-1:0] amp);
    logic              low;
    logic [DUTY_W-1:0] mag;
    logic [DUTY_W:0]   twice;
    logic [DUTY_W-1:0] span;
    logic [2*DUTY_W-1:0] prod;
    logic [DUTY_W:0]   sum;
    logic [DUTY_W-1:0] res;
    low   = ~raw[DUTY_W-1];
    mag   = low ? ~raw : raw;
    twice = {mag, 1'b0} - {1'b0, DUTY_FULL};
    span  = twice[DUTY_W-1:0];
    prod  = span * amp;
    sum   = {1'b0, prod[2*DUTY_W-1:DUTY_W]} + {1'b0, DUTY_FULL};
    res   = sum[DUTY_W:1] + 8'd1;
    return low ? ~res : res;
  endfunction

endpackage

// ----- src/spwm_period_rom.sv -----
module spwm_period_rom (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [spwm_pkg::SPEED_W-1:0]      addr_i,
  output logic [spwm_pkg::PER_W-1:0]        data_o
);

  localparam int unsigned ROM_DEPTH = 2 ** spwm_pkg::SPEED_W;

  logic [spwm_pkg::PER_W-1:0] rom_w [ROM_DEPTH];
  logic [spwm_pkg::PER_W-1:0] data_q;

  // rounded carrier period minus one, zero for stopped and unused entries
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_entry
    localparam int unsigned S = g;
    localparam int unsigned B = (S > spwm_pkg::BAND4) ? 4 :
                                (S > spwm_pkg::BAND3) ? 3 :
                                (S > spwm_pkg::BAND2) ? 2 :
                                (S > spwm_pkg::BAND1) ? 1 : 0;
    localparam int unsigned NUM = spwm_pkg::PERIOD_NUM << B;
    localparam int unsigned D   = S + spwm_pkg::PERIOD_OFS;
    localparam int unsigned P   = (S == 0 || S > spwm_pkg::SPEED_TOP) ? 0 :
                                  (2 * NUM + D - 1) / (2 * D) - 1;
    assign rom_w[g] = spwm_pkg::PER_W'(P);
  end

  // registered read, held while the result waits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ----- src/spwm_ramp.sv -----
module spwm_ramp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [spwm_pkg::SPEED_W-1:0]    target_i,
  input  logic [spwm_pkg::CNT_W-1:0]      accel_i,
  input  logic [spwm_pkg::CNT_W-1:0]      decel_i,
  output spwm_pkg::ramp_stat_t            stat_o,
  output logic [spwm_pkg::SPEED_W-1:0]    speed_nxt_o
);

  logic [spwm_pkg::SPEED_W-1:0] speed_q, speed_d;
  logic [spwm_pkg::CNT_W-1:0]   up_q, up_d, down_q, down_d;
  logic [spwm_pkg::CNT_W-1:0]   up_inc, down_inc;
  logic [spwm_pkg::DUTY_W-1:0]  quo_q, quo_d;
  logic [spwm_pkg::REM_W-1:0]   rem_q, rem_d;
  logic                         inc, dec;

  assign up_inc   = up_q + 8'd1;
  assign down_inc = down_q + 8'd1;

  // tick counting toward the target
  always_comb begin
    up_d   = up_q;
    down_d = down_q;
    inc    = 1'b0;
    dec    = 1'b0;
    if (step_i) begin
      if (speed_q == target_i) begin
        up_d   = '0;
        down_d = '0;
      end else if (speed_q < target_i) begin
        down_d = '0;
        if (up_inc == accel_i) begin
          up_d = '0;
          inc  = 1'b1;
        end else begin
          up_d = up_inc;
        end
      end else begin
        up_d = '0;
        if (down_inc == decel_i) begin
          down_d = '0;
          dec    = 1'b1;
        end else begin
          down_d = down_inc;
        end
      end
    end
  end

  // speed step and incremental v/f amplitude on the sloped part of the curve
  always_comb begin
    speed_d = speed_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (inc) begin
      speed_d = speed_q + 10'd1;
      if (speed_q >= spwm_pkg::SPD_BOOST && speed_q < spwm_pkg::SPD_BASE) begin
        if (rem_q >= spwm_pkg::AMP_WRAP) begin
          rem_d = rem_q - spwm_pkg::AMP_WRAP;
          quo_d = quo_q + 8'd1;
        end else begin
          rem_d = rem_q + spwm_pkg::AMP_STEP;
        end
      end
    end else if (dec) begin
      speed_d = speed_q - 10'd1;
      if (speed_q > spwm_pkg::SPD_BOOST && speed_q <= spwm_pkg::SPD_BASE) begin
        if (rem_q >= spwm_pkg::AMP_STEP) begin
          rem_d = rem_q - spwm_pkg::AMP_STEP;
        end else begin
          rem_d = rem_q + spwm_pkg::AMP_WRAP;
          quo_d = quo_q - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      up_q    <= '0;
      down_q  <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
    end else begin
      speed_q <= speed_d;
      up_q    <= up_d;
      down_q  <= down_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
    end
  end

  assign stat_o.speed = speed_q;
  assign stat_o.amp   = spwm_pkg::AMP_LOW + quo_q;
  assign speed_nxt_o  = speed_d;

  // remainder stays below the slope denominator
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < spwm_pkg::AMP_DEN)
    else $error("amplitude remainder out of range");

  // speed only moves on a ramp tick
  a_speed_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(speed_q))
    else $error("speed moved without a ramp tick");

  // speed never leaves its range
  a_speed_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= spwm_pkg::SPEED_TOP)
    else $error("speed above top");

endmodule

// ----- src/spwm_wave.sv -----
module spwm_wave (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            sample_i,
  input  spwm_pkg::ramp_stat_t            stat_i,
  output logic [spwm_pkg::DUTY_W-1:0]     duty_a_o,
  output logic [spwm_pkg::DUTY_W-1:0]     duty_b_o,
  output logic [spwm_pkg::DUTY_W-1:0]     duty_c_o
);

  logic [spwm_pkg::DUTY_W-1:0] phase_q, phase_d;
  logic [spwm_pkg::DUTY_W-1:0] duty_a_q, duty_a_d;
  logic [spwm_pkg::DUTY_W-1:0] duty_b_q, duty_b_d;
  logic [spwm_pkg::DUTY_W-1:0] duty_c_q, duty_c_d;
  logic [spwm_pkg::DUTY_W-1:0] stride, phase_nxt;
  logic [spwm_pkg::DUTY_W-1:0] raw_a, raw_b, raw_c;
  logic                        run, full;

  // phase stride doubles with each speed band
  assign stride    = 8'd1 << spwm_pkg::band_of(stat_i.speed);
  assign phase_nxt = phase_q + stride;
  assign run       = sample_i && (stat_i.speed != '0);
  assign full      = stat_i.speed >= spwm_pkg::SPD_BASE;

  // three sine lookups
  assign raw_a = spwm_pkg::wave_rom(phase_nxt);
  assign raw_b = spwm_pkg::wave_rom(phase_nxt + spwm_pkg::OFS_B);
  assign raw_c = spwm_pkg::wave_rom(phase_nxt + spwm_pkg::OFS_C);

  // scale and hold the compare values
  always_comb begin
    phase_d  = phase_q;
    duty_a_d = duty_a_q;
    duty_b_d = duty_b_q;
    duty_c_d = duty_c_q;
    if (run) begin
      phase_d = phase_nxt;
      if (full) begin
        duty_a_d = raw_a;
        duty_b_d = raw_b;
        duty_c_d = raw_c;
      end else begin
        duty_a_d = spwm_pkg::scale_sample(raw_a, stat_i.amp);
        duty_b_d = spwm_pkg::scale_sample(raw_b, stat_i.amp);
        duty_c_d = spwm_pkg::scale_sample(raw_c, stat_i.amp);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      duty_a_q <= spwm_pkg::DUTY_RST_A;
      duty_b_q <= spwm_pkg::DUTY_RST_B;
      duty_c_q <= spwm_pkg::DUTY_RST_C;
    end else begin
      phase_q  <= phase_d;
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
      duty_c_q <= duty_c_d;
    end
  end

  assign duty_a_o = duty_a_q;
  assign duty_b_o = duty_b_q;
  assign duty_c_o = duty_c_q;

endmodule

// ----- src/three_phase_spwm_vf_ramp.sv -----
// Three-phase sine PWM compare generator with a volts-per-hertz speed ramp.
// Input stream: tuser[0] is the command (ramp tick or carrier sample tick),
// tdata[9:0] the target speed. Every input transfer gives one output transfer.
// Output stream: tdata carries the three phase compare values, the drive
// enable flag and the sample timer period for the current speed.
// An accepted item is held in the input register, then updates the
// ramp and waveform state in one pass; that state, together with the
// registered period table read, is the result register. One item per
// cycle is sustained while the receiver does not stall.
// The period table is a 1024-entry constant ROM read with the next speed,
// so the period is ready on the same edge as the rest of the result.
// When the receiver stalls, the result holds and the input register keeps
// one item; tready drops only once both are full.
// Reset clears speed, tick counts and phase, sets the compare values to
// their idle pattern and both tick registers to one. The user must write the
// tick registers only while no item is in flight; the block does not enforce it.
module three_phase_spwm_vf_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // target_speed[9:0], zero fill
  input  logic [0:0]  s_axis_tuser,   // cmd[0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // duty_a[7:0], duty_b[15:8], duty_c[23:16],
                                      // outputs_on[24], period_value[40:25], zero fill
);

  logic [spwm_pkg::CNT_W-1:0]   accel_q, decel_q;
  logic                         in_valid_q, in_valid_d;
  spwm_pkg::cmd_e               in_cmd_q;
  logic [spwm_pkg::SPEED_W-1:0] in_tgt_q;
  logic                         out_valid_q, out_valid_d;
  logic                         out_ready, process, in_take;
  logic [spwm_pkg::SPEED_W-1:0] target_sat, speed_nxt;
  spwm_pkg::ramp_stat_t         stat;
  logic [spwm_pkg::DUTY_W-1:0]  duty_a, duty_b, duty_c;
  logic [spwm_pkg::PER_W-1:0]   period;
  logic                         outputs_on;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= spwm_pkg::TICKS_RST;
      decel_q <= spwm_pkg::TICKS_RST;
    end else if (cfg_we_i) begin
      case (spwm_pkg::cfg_idx_e'(cfg_addr_i))
        spwm_pkg::CFG_ACCEL: accel_q <= cfg_wdata_i;
        spwm_pkg::CFG_DECEL: decel_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (process) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= spwm_pkg::cmd_e'(s_axis_tuser[0]);
      in_tgt_q <= s_axis_tdata[spwm_pkg::SPEED_W-1:0];
    end
  end

  // saturate the target to the top speed
  assign target_sat = (in_tgt_q > spwm_pkg::SPEED_TOP) ? spwm_pkg::SPEED_TOP : in_tgt_q;

  spwm_ramp u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (process && in_cmd_q == spwm_pkg::CMD_RAMP),
    .target_i    (target_sat),
    .accel_i     (accel_q),
    .decel_i     (decel_q),
    .stat_o      (stat),
    .speed_nxt_o (speed_nxt)
  );

  spwm_wave u_wave (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (process && in_cmd_q == spwm_pkg::CMD_SAMPLE),
    .stat_i   (stat),
    .duty_a_o (duty_a),
    .duty_b_o (duty_b),
    .duty_c_o (duty_c)
  );

  spwm_period_rom u_period (
    .clk_i  (clk_i),
    .en_i   (process),
    .addr_i (speed_nxt),
    .data_o (period)
  );

  assign outputs_on    = stat.speed != '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, period, outputs_on, duty_c, duty_b, duty_a};

  // a blocked item stays in the input register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_ready |=> in_valid_q && $stable(in_tgt_q))
    else $error("input item lost while blocked");

  // period is zero exactly when stopped
  a_period_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((period == '0) == (stat.speed == '0)))
    else $error("period does not match speed");

  // a sample tick never moves the speed
  a_sample_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && in_cmd_q == spwm_pkg::CMD_SAMPLE |=> $stable(stat.speed))
    else $error("sample tick changed speed");

endmodule

// ----- sim/tb.sv -----
module tb;
  import spwm_pkg::*;

  // compare values, drive flag and timer period for one result
  typedef struct {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic              outputs_on;
    logic [PER_W-1:0]  period;
  } drive_word_t;

  // tracks ramp and waveform state, holds the drive words still to come
  class duty_scoreboard;
    logic [CNT_W-1:0]   accel_reg;
    logic [CNT_W-1:0]   decel_reg;
    logic [SPEED_W-1:0] spd;
    logic [CNT_W-1:0]   up_run;
    logic [CNT_W-1:0]   down_run;
    logic [DUTY_W-1:0]  phase;
    logic [DUTY_W-1:0]  duty [3];
    drive_word_t        pending_words [$];
    int                 errors;
    int                 n_ramp;
    int                 n_sample;
    int                 n_checked;
    logic [SPEED_W-1:0] top_spd;

    function new();
      accel_reg = TICKS_RST;
      decel_reg = TICKS_RST;
      spd       = '0;
      up_run    = '0;
      down_run  = '0;
      phase     = '0;
      duty[0]   = DUTY_RST_A;
      duty[1]   = DUTY_RST_B;
      duty[2]   = DUTY_RST_C;
      errors    = 0;
      n_ramp    = 0;
      n_sample  = 0;
      n_checked = 0;
      top_spd   = '0;
    endfunction

    function void set_ticks(cfg_idx_e idx, logic [CNT_W-1:0] val);
      if (idx == CFG_ACCEL) accel_reg = val;
      else decel_reg = val;
    endfunction

    // shift of the phase stride for a speed
    function int unsigned stride_shift(logic [SPEED_W-1:0] s);
      if (s > 10'd795) return 4;
      if (s > 10'd595) return 3;
      if (s > 10'd395) return 2;
      if (s > 10'd195) return 1;
      return 0;
    endfunction

    // rounded carrier period for a speed, minus one
    function logic [PER_W-1:0] period_for(logic [SPEED_W-1:0] s);
      int unsigned num;
      int unsigned d;
      if (s == '0) return '0;
      num = 32'd312500 << stride_shift(s);
      d   = 32'(s) + 32'd4;
      return PER_W'((2 * num + d - 1) / (2 * d) - 1);
    endfunction

    // shrink a sine sample toward mid-scale by the v/f amplitude
    function logic [DUTY_W-1:0] pull_to_mid(logic [DUTY_W-1:0] raw, logic [DUTY_W-1:0] amp);
      logic              low;
      logic [DUTY_W-1:0] mag;
      logic [DUTY_W-1:0] res;
      int unsigned       t;
      low = raw < 8'd128;
      mag = low ? ~raw : raw;
      t   = 2 * 32'(mag) - 255;
      t   = (t * 32'(amp)) & 32'hFFFF;
      t   = t >> 8;
      t   = (t + 255) >> 1;
      res = DUTY_W'(t + 1);
      return low ? ~res : res;
    endfunction

    // advance the predicted state for one accepted input transfer
    function void note_tick(cmd_e cmd, logic [SPEED_W-1:0] tgt_in);
      logic [SPEED_W-1:0] tgt;
      logic [DUTY_W-1:0]  amp;
      logic [DUTY_W-1:0]  idx;
      drive_word_t        w;
      tgt = (tgt_in > 10'd996) ? 10'd996 : tgt_in;
      if (cmd == CMD_RAMP) begin
        n_ramp++;
        if (spd == tgt) begin
          up_run   = '0;
          down_run = '0;
        end else if (spd < tgt) begin
          down_run = '0;
          up_run   = up_run + 8'd1;
          if (up_run == accel_reg) begin
            up_run = '0;
            spd    = spd + 10'd1;
          end
        end else begin
          up_run   = '0;
          down_run = down_run + 8'd1;
          if (down_run == decel_reg) begin
            down_run = '0;
            spd      = spd - 10'd1;
          end
        end
      end else begin
        n_sample++;
        if (spd != '0) begin
          phase = phase + DUTY_W'(1 << stride_shift(spd));
          for (int k = 0; k < 3; k++) begin
            idx = phase + ((k == 0) ? 8'd0 : (k == 1) ? 8'd84 : 8'd170);
            if (spd >= 10'd495) begin
              duty[k] = WAVE_TAB[idx];
            end else begin
              if (spd <= 10'd95) amp = 8'd25;
              else amp = DUTY_W'(230 * (int'(spd) - 95) / 400 + 25);
              duty[k] = pull_to_mid(WAVE_TAB[idx], amp);
            end
          end
        end
      end
      if (spd > top_spd) top_spd = spd;
      w.duty_a     = duty[0];
      w.duty_b     = duty[1];
      w.duty_c     = duty[2];
      w.outputs_on = (spd != '0);
      w.period     = period_for(spd);
      pending_words.push_back(w);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // compare one output transfer with the oldest predicted word
    function void check_result(logic [47:0] data);
      drive_word_t w;
      if (pending_words.size() == 0) begin
        $error("output transfer with nothing predicted: %h", data);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      n_checked++;
      compare("duty_a", w.duty_a, data[7:0]);
      compare("duty_b", w.duty_b, data[15:8]);
      compare("duty_c", w.duty_c, data[23:16]);
      compare("outputs_on", w.outputs_on, data[24]);
      compare("period_value", w.period, data[40:25]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_addr_i = '0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  duty_scoreboard sb;

  three_phase_spwm_vf_ramp dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watch both streams
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_tick(cmd_e'(s_axis_tuser[0]), s_axis_tdata[9:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready <= !(idle_on && $urandom_range(99) < 20);
    end
  end

  // safety limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // offer one item and wait for its transfer
  task automatic send_tick(input cmd_e cmd, input logic [SPEED_W-1:0] tgt);
    while (idle_on && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, tgt};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait until every predicted word has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ticks(input cfg_idx_e idx, input logic [CNT_W-1:0] val);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_ticks(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  // runs of ramp ticks toward one target, mixed with sample ticks and noise
  task automatic run_segments(input int n_items);
    int          sent;
    int          seg_len;
    int          near_tgt;
    int unsigned pick;
    logic [SPEED_W-1:0] seg_tgt;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        seg_tgt = '0;
      end else if (pick < 20) begin
        seg_tgt = SPEED_W'($urandom_range(1023, 997));
      end else if (pick < 60) begin
        near_tgt = int'(sb.spd) + int'($urandom_range(16)) - 8;
        if (near_tgt < 0) near_tgt = 0;
        seg_tgt = SPEED_W'(near_tgt);
      end else begin
        seg_tgt = SPEED_W'($urandom_range(1023));
      end
      seg_len = $urandom_range(40, 5);
      for (int k = 0; k < seg_len; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) send_tick(CMD_RAMP, seg_tgt);
        else if (pick < 93) send_tick(CMD_SAMPLE, SPEED_W'($urandom_range(1023)));
        else send_tick(CMD_RAMP, SPEED_W'($urandom_range(1023)));
      end
      sent += seg_len;
    end
  endtask

  // main sequence
  initial begin
    int          n_climb;
    int unsigned pick;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: stop, start, saturation, ignored target, at-target clear
    send_tick(CMD_SAMPLE, 10'd1023);
    send_tick(CMD_RAMP, 10'd0);
    send_tick(CMD_RAMP, 10'd1023);
    send_tick(CMD_SAMPLE, 10'd0);
    send_tick(CMD_SAMPLE, 10'd512);
    send_tick(CMD_RAMP, 10'd1);
    send_tick(CMD_RAMP, 10'd0);
    send_tick(CMD_SAMPLE, 10'h155);
    send_tick(CMD_RAMP, 10'd997);
    send_tick(CMD_RAMP, 10'h2aa);
    send_tick(CMD_RAMP, 10'd996);
    send_tick(CMD_SAMPLE, 10'd1023);

    // directed: multi-tick steps and direction change clearing the count
    write_ticks(CFG_ACCEL, 8'd3);
    write_ticks(CFG_DECEL, 8'd2);
    repeat (4) send_tick(CMD_RAMP, 10'd1023);
    send_tick(CMD_RAMP, 10'd0);
    send_tick(CMD_RAMP, 10'd0);
    send_tick(CMD_SAMPLE, 10'd0);
    send_tick(CMD_RAMP, 10'd3);

    // climb to top speed through every band, with a hold-off and a drain
    write_ticks(CFG_ACCEL, 8'd1);
    write_ticks(CFG_DECEL, 8'd1);
    n_climb = 0;
    while (sb.spd < 10'd996) begin
      if (n_climb == 250) hold_req <= 1'b1;
      if (n_climb == 500) wait_drained();
      if (n_climb == 650) idle_on <= 1'b0;
      if (n_climb == 850) idle_on <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 93) send_tick(CMD_RAMP, SPEED_W'($urandom_range(1023, 996)));
      else if (pick < 99) send_tick(CMD_SAMPLE, SPEED_W'($urandom_range(1023)));
      else send_tick(CMD_RAMP, SPEED_W'($urandom_range(1023)));
      n_climb++;
    end
    repeat (8) send_tick(CMD_SAMPLE, SPEED_W'($urandom_range(1023)));

    // slowest rise, fastest fall
    write_ticks(CFG_ACCEL, 8'd0);
    run_segments(30);

    // widest setting up, 256-tick fall, then a run of falling ticks
    write_ticks(CFG_ACCEL, 8'd255);
    write_ticks(CFG_DECEL, 8'd0);
    run_segments(20);
    repeat (20) send_tick(CMD_RAMP, 10'd0);

    // fall count now above the new setting, so it wraps before stepping
    write_ticks(CFG_ACCEL, 8'd2);
    write_ticks(CFG_DECEL, 8'd3);
    run_segments(30);

    write_ticks(CFG_ACCEL, 8'd1);
    write_ticks(CFG_DECEL, 8'd255);
    run_segments(20);

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d ramp ticks and %0d sample ticks, %0d results checked",
             sb.n_ramp, sb.n_sample, sb.n_checked);
    $display("highest speed reached %0d, tick settings down to 0 and up to 255",
             sb.top_spd);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
